@@ design/arwt_pkg.sv @@
// arwt_pkg: shared types and constants for the activity run window tracker
// no dependencies; used by arwt_ctrl, arwt_out, the top level and the checker by scoped names

package arwt_pkg;

  localparam int WINDOW_SECONDS_DEF = 3600;
  localparam int RUN_DEPTH_DEF      = 4096;

  localparam int KIND_W = 3;
  localparam int LEN_W  = 12;
  localparam int GAP_W  = 12;
  localparam int WORD_W = KIND_W + LEN_W;

  localparam logic [GAP_W-1:0]  GAP_RESET   = 12'd60;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PATTER = 3'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
  } run_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind0;
    logic [LEN_W-1:0]  len0;
    logic [KIND_W-1:0] kind1;
    logic [LEN_W-1:0]  len1;
    logic              has_prev;
    logic              dropped;
  } res_t;

endpackage

@@ design/arwt_ram.sv @@
// arwt_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies

module arwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/arwt_ctrl.sv @@
// arwt_ctrl: sequencer that reads, modifies and writes back the run ring
// depends on arwt_pkg; drives the run memory and hands results to arwt_out

module arwt_ctrl #(
  parameter int WINDOW_SECONDS = arwt_pkg::WINDOW_SECONDS_DEF,
  parameter int RUN_DEPTH      = arwt_pkg::RUN_DEPTH_DEF,
  localparam int AW = $clog2(RUN_DEPTH),
  localparam int CW = $clog2(RUN_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [arwt_pkg::KIND_W-1:0]   in_activity_type,
  input  logic                          cfg_wr_en,
  input  logic [arwt_pkg::GAP_W-1:0]    cfg_wr_data,
  output logic [arwt_pkg::GAP_W-1:0]    gap_limit,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [arwt_pkg::WORD_W-1:0]   ram_wdata,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [arwt_pkg::WORD_W-1:0]   ram_rdata,
  output arwt_pkg::res_t                res,
  output logic                          res_valid,
  input  logic                          out_free
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_TAIL_RD, S_TAIL_CHK, S_NEW_RD, S_NEW_CHK, S_OLD_RD, S_OLD_CHK,
    S_MRG_RD0, S_MRG_RD1, S_MRG_RD2, S_MRG_CHK, S_OUT_RD0, S_OUT_RD1, S_OUT_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   nptr_r, nptr_nxt;
  logic [AW-1:0]                   optr_r, optr_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [arwt_pkg::GAP_W-1:0]      gap_r, gap_nxt;
  logic                            phase_r, phase_nxt;
  logic                            dropped_r, dropped_nxt;
  logic                            prev_r, prev_nxt;
  logic [arwt_pkg::KIND_W-1:0]     ty_r, ty_nxt;
  logic [arwt_pkg::KIND_W-1:0]     t0_r, t0_nxt, t1_r, t1_nxt;
  logic [arwt_pkg::LEN_W-1:0]      l0_r, l0_nxt, l1_r, l1_nxt;

  arwt_pkg::run_t                  rd;
  arwt_pkg::run_t                  wr;
  logic [AW-1:0]                   n_inc, n_dec1, n_dec2, o_inc;
  logic                            full;
  logic                            merge_ok;
  logic [arwt_pkg::LEN_W+1:0]      merge_sum;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RUN_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(RUN_DEPTH - 1) : p - 1'b1;
  endfunction

  assign rd        = arwt_pkg::run_t'(ram_rdata);
  assign ram_wdata = wr;
  assign n_inc     = ptr_inc(nptr_r);
  assign n_dec1    = ptr_dec(nptr_r);
  assign n_dec2    = ptr_dec(n_dec1);
  assign o_inc     = ptr_inc(optr_r);
  assign full      = (cnt_r == CW'(RUN_DEPTH));
  assign merge_sum = {2'b00, l0_r} + {2'b00, l1_r} + {2'b00, rd.len};
  assign merge_ok  = (t0_r == rd.kind) && (t0_r != arwt_pkg::KIND_IDLE) &&
                     (t1_r == arwt_pkg::KIND_IDLE) && (l1_r != '0) && (l1_r < gap_r);

  assign in_ready  = (state_r == S_IDLE);
  assign gap_limit = gap_r;

  assign res.kind0    = t0_r;
  assign res.len0     = l0_r;
  assign res.kind1    = rd.kind;
  assign res.len1     = rd.len;
  assign res.has_prev = prev_r;
  assign res.dropped  = dropped_r;

  always_comb begin
    state_nxt   = state_r;
    nptr_nxt    = nptr_r;
    optr_nxt    = optr_r;
    cnt_nxt     = cnt_r;
    gap_nxt     = cfg_wr_en ? cfg_wr_data : gap_r;
    phase_nxt   = phase_r;
    dropped_nxt = dropped_r;
    prev_nxt    = prev_r;
    ty_nxt      = ty_r;
    t0_nxt      = t0_r;
    l0_nxt      = l0_r;
    t1_nxt      = t1_r;
    l1_nxt      = l1_r;
    ram_we      = 1'b0;
    ram_waddr   = nptr_r;
    wr          = '0;
    ram_re      = 1'b0;
    ram_raddr   = nptr_r;
    res_valid   = 1'b0;
    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        wr.kind   = arwt_pkg::KIND_IDLE;
        wr.len    = arwt_pkg::LEN_W'(WINDOW_SECONDS);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ty_nxt      = in_activity_type;
          dropped_nxt = 1'b0;
          if (in_command) begin
            if (full) begin
              dropped_nxt = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = n_inc;
              wr.kind   = arwt_pkg::KIND_IDLE;
              wr.len    = '0;
              nptr_nxt  = n_inc;
              cnt_nxt   = cnt_r + 1'b1;
            end
            state_nxt = S_OUT_RD0;
          end else begin
            phase_nxt = 1'b0;
            state_nxt = S_TAIL_RD;
          end
        end
      end
      S_TAIL_RD: begin
        if (cnt_r > CW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = optr_r;
          state_nxt = S_TAIL_CHK;
        end else begin
          state_nxt = phase_r ? S_OUT_RD0 : S_NEW_RD;
        end
      end
      S_TAIL_CHK: begin
        if (rd.len == '0) begin
          optr_nxt  = o_inc;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_TAIL_RD;
        end else begin
          state_nxt = phase_r ? S_OUT_RD0 : S_NEW_RD;
        end
      end
      S_NEW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = nptr_r;
        state_nxt = S_NEW_CHK;
      end
      S_NEW_CHK: begin
        if (rd.kind == ty_r) begin
          if (cnt_r == CW'(1)) begin
            // single run: one second in and one out leaves it as it is
            phase_nxt = 1'b1;
            state_nxt = S_TAIL_RD;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = nptr_r;
            wr.kind   = rd.kind;
            wr.len    = rd.len + 1'b1;
            state_nxt = S_OLD_RD;
          end
        end else begin
          if (full) begin
            optr_nxt = o_inc;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
          ram_we    = 1'b1;
          ram_waddr = n_inc;
          wr.kind   = ty_r;
          wr.len    = arwt_pkg::LEN_W'(1);
          nptr_nxt  = n_inc;
          state_nxt = S_OLD_RD;
        end
      end
      S_OLD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = optr_r;
        state_nxt = S_OLD_CHK;
      end
      S_OLD_CHK: begin
        if (rd.len != '0) begin
          ram_we    = 1'b1;
          ram_waddr = optr_r;
          wr.kind   = rd.kind;
          wr.len    = rd.len - 1'b1;
        end
        if ((rd.len <= arwt_pkg::LEN_W'(1)) && (cnt_r > CW'(1))) begin
          optr_nxt = o_inc;
          cnt_nxt  = cnt_r - 1'b1;
        end
        state_nxt = S_MRG_RD0;
      end
      S_MRG_RD0: begin
        phase_nxt = 1'b1;
        if (cnt_r >= CW'(3)) begin
          ram_re    = 1'b1;
          ram_raddr = nptr_r;
          state_nxt = S_MRG_RD1;
        end else begin
          state_nxt = S_TAIL_RD;
        end
      end
      S_MRG_RD1: begin
        t0_nxt    = rd.kind;
        l0_nxt    = rd.len;
        ram_re    = 1'b1;
        ram_raddr = n_dec1;
        state_nxt = S_MRG_RD2;
      end
      S_MRG_RD2: begin
        t1_nxt    = rd.kind;
        l1_nxt    = rd.len;
        ram_re    = 1'b1;
        ram_raddr = n_dec2;
        state_nxt = S_MRG_CHK;
      end
      S_MRG_CHK: begin
        if (merge_ok) begin
          ram_we    = 1'b1;
          ram_waddr = n_dec2;
          wr.kind   = t0_r;
          wr.len    = merge_sum[arwt_pkg::LEN_W-1:0];
          nptr_nxt  = n_dec2;
          cnt_nxt   = cnt_r - CW'(2);
        end
        state_nxt = S_TAIL_RD;
      end
      S_OUT_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = nptr_r;
        state_nxt = S_OUT_RD1;
      end
      S_OUT_RD1: begin
        t0_nxt   = rd.kind;
        l0_nxt   = rd.len;
        prev_nxt = (cnt_r >= CW'(2));
        if (cnt_r >= CW'(2)) begin
          ram_re    = 1'b1;
          ram_raddr = n_dec1;
        end
        state_nxt = S_OUT_FIN;
      end
      S_OUT_FIN: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      nptr_r    <= '0;
      optr_r    <= '0;
      cnt_r     <= CW'(1);
      gap_r     <= arwt_pkg::GAP_RESET;
      phase_r   <= 1'b0;
      dropped_r <= 1'b0;
      prev_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      nptr_r    <= nptr_nxt;
      optr_r    <= optr_nxt;
      cnt_r     <= cnt_nxt;
      gap_r     <= gap_nxt;
      phase_r   <= phase_nxt;
      dropped_r <= dropped_nxt;
      prev_r    <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ty_r <= ty_nxt;
    t0_r <= t0_nxt;
    l0_r <= l0_nxt;
    t1_r <= t1_nxt;
    l1_r <= l1_nxt;
  end

endmodule

@@ design/arwt_out.sv @@
// arwt_out: result decode (patter bridging, break length) and output register
// depends on arwt_pkg; fed by arwt_ctrl

module arwt_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  arwt_pkg::res_t             res,
  input  logic                       res_valid,
  input  logic [arwt_pkg::GAP_W-1:0] gap_limit,
  output logic                       out_free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_patter_active,
  output logic [arwt_pkg::LEN_W-1:0] out_patter_seconds,
  output logic                       out_break_active,
  output logic [arwt_pkg::LEN_W-1:0] out_break_seconds,
  output logic                       out_stop_dropped
);

  logic                       valid_r;
  logic                       pat_on_r, brk_on_r, drop_r;
  logic [arwt_pkg::LEN_W-1:0] pat_len_r, brk_len_r;
  logic                       pat_on, brk_on, bridge, load;
  logic [arwt_pkg::LEN_W-1:0] pat_len, brk_len;
  logic [arwt_pkg::LEN_W:0]   bridge_sum;

  assign out_free   = !valid_r || out_ready;
  assign load       = res_valid && out_free;
  assign bridge_sum = {1'b0, res.len0} + {1'b0, res.len1};
  assign bridge     = (res.kind0 == arwt_pkg::KIND_IDLE) && (res.len0 < gap_limit) &&
                      res.has_prev && (res.kind1 == arwt_pkg::KIND_PATTER);

  always_comb begin
    pat_on  = 1'b0;
    pat_len = '0;
    brk_on  = 1'b0;
    brk_len = '0;
    priority if (bridge) begin
      pat_on  = 1'b1;
      pat_len = bridge_sum[arwt_pkg::LEN_W-1:0];
    end else if (res.kind0 == arwt_pkg::KIND_PATTER) begin
      pat_on  = 1'b1;
      pat_len = res.len0;
    end else if (res.kind0 == arwt_pkg::KIND_IDLE) begin
      brk_on  = 1'b1;
      brk_len = res.len0;
    end else begin
      pat_on = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat_on_r  <= pat_on;
      pat_len_r <= pat_len;
      brk_on_r  <= brk_on;
      brk_len_r <= brk_len;
      drop_r    <= res.dropped;
    end
  end

  assign out_valid          = valid_r;
  assign out_patter_active  = pat_on_r;
  assign out_patter_seconds = pat_len_r;
  assign out_break_active   = brk_on_r;
  assign out_break_seconds  = brk_len_r;
  assign out_stop_dropped   = drop_r;

endmodule

@@ design/activity_run_window_tracker.sv @@
// activity_run_window_tracker: top level of the run window tracker
// depends on arwt_pkg, arwt_ram, arwt_ctrl, arwt_out
//
//   channel  | handshake              | payload
//   in       | in_valid / in_ready    | in_command, in_activity_type
//   out      | out_valid / out_ready  | patter and break flags and seconds, stop_dropped
//   cfg      | cfg_wr_en              | cfg_wr_data (gap limit)
//
// a stop and a tick each run as a sequence of states; a tick also drops each empty run
// at the tail; the sequence is set by the one-read-port read-modify-write on the run memory
// reset: the init state writes slot zero of the run memory, in_ready stays low meanwhile
// one transaction at a time; the result register lets the next transaction in while
// a result waits, and the sequencer holds its last step until that register is free

module activity_run_window_tracker #(
  parameter int WINDOW_SECONDS = arwt_pkg::WINDOW_SECONDS_DEF,
  parameter int RUN_DEPTH      = arwt_pkg::RUN_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [arwt_pkg::KIND_W-1:0] in_activity_type,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_patter_active,
  output logic [arwt_pkg::LEN_W-1:0]  out_patter_seconds,
  output logic                        out_break_active,
  output logic [arwt_pkg::LEN_W-1:0]  out_break_seconds,
  output logic                        out_stop_dropped,
  input  logic                        cfg_wr_en,
  input  logic [arwt_pkg::GAP_W-1:0]  cfg_wr_data
);

  localparam int AW = $clog2(RUN_DEPTH);

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [arwt_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
  arwt_pkg::res_t              res;
  logic                        res_valid, out_free;
  logic [arwt_pkg::GAP_W-1:0]  gap_limit;

  arwt_ram #(
    .WIDTH (arwt_pkg::WORD_W),
    .DEPTH (RUN_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  arwt_ctrl #(
    .WINDOW_SECONDS (WINDOW_SECONDS),
    .RUN_DEPTH      (RUN_DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_activity_type (in_activity_type),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .gap_limit        (gap_limit),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .res              (res),
    .res_valid        (res_valid),
    .out_free         (out_free)
  );

  arwt_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .res                (res),
    .res_valid          (res_valid),
    .gap_limit          (gap_limit),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_patter_active  (out_patter_active),
    .out_patter_seconds (out_patter_seconds),
    .out_break_active   (out_break_active),
    .out_break_seconds  (out_break_seconds),
    .out_stop_dropped   (out_stop_dropped)
  );

endmodule

@@ design/arwt_checker.sv @@
// arwt_checker: port-level assertions for the run window tracker, bound to the top level
// depends on arwt_pkg for field widths

module arwt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_command,
  input logic [arwt_pkg::KIND_W-1:0] in_activity_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_patter_active,
  input logic [arwt_pkg::LEN_W-1:0]  out_patter_seconds,
  input logic                        out_break_active,
  input logic [arwt_pkg::LEN_W-1:0]  out_break_seconds,
  input logic                        out_stop_dropped
);

  // one transaction at a time: busy straight after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high the cycle after an input transaction");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_command) &&
      $stable(in_activity_type)))
    else $error("waiting input transaction changed or vanished");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_patter_active) &&
      $stable(out_patter_seconds) && $stable(out_break_active) &&
      $stable(out_break_seconds) && $stable(out_stop_dropped)))
    else $error("stalled result changed or vanished");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_patter_active && out_break_active))
    else $error("patter and break both active");

  a_zero_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_patter_active || (out_patter_seconds == '0)) &&
      (out_break_active || (out_break_seconds == '0))))
    else $error("seconds non-zero on an inactive field");

endmodule

bind activity_run_window_tracker arwt_checker u_arwt_checker (.*);
